// ===== src/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg: shared constants for the RGB/HSV converter.
// Holds the field widths, the fixed-point formats and the direction codes.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int HUE_FRAC_BITS_DEF  = 6;
  localparam int UNIT_FRAC_BITS_DEF = 15;

  localparam int BYTE_W = 8;
  localparam int HUE_W  = 15;
  localparam int UNIT_W = 16;

  // Direction codes carried in the mode field.
  localparam logic MODE_RGB2HSV = 1'b0;
  localparam logic MODE_HSV2RGB = 1'b1;

endpackage

// ===== src/rhc_if.sv =====
// ----------------------------------------------------------------------------
// rhc_in_if / rhc_out_if: valid/ready channels of the converter.
// An item moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface rhc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [14:0] hue;
  logic [15:0] sat;
  logic [15:0] bri;
  modport source (output valid, mode, red, green, blue, hue, sat, bri, input ready);
  modport sink   (input valid, mode, red, green, blue, hue, sat, bri, output ready);
endinterface

interface rhc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [14:0] hue;
  logic [15:0] sat;
  logic [15:0] bri;
  modport source (output valid, red, green, blue, hue, sat, bri, input ready);
  modport sink   (input valid, red, green, blue, hue, sat, bri, output ready);
endinterface

// ===== src/rhc_divider.sv =====
// ----------------------------------------------------------------------------
// rhc_divider: pipelined restoring divider, one quotient bit per stage.
// Carries a side payload of fixed width alongside each division.
// ----------------------------------------------------------------------------
module rhc_divider #(
  parameter int NUM_W  = 40,
  parameter int DEN_W  = 24,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    // Partial remainder, shifting numerator/quotient, divisor and side data.
    logic [DEN_W:0]    rem_r;
    logic [NUM_W-1:0]  quo_r;
    logic [DEN_W-1:0]  den_r;
    logic [SIDE_W-1:0] side_r;
    logic              vld_r;
    // Values entering this stage.
    logic [DEN_W:0]    rem_p;
    logic [NUM_W-1:0]  quo_p;
    logic [DEN_W-1:0]  den_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [DEN_W+1:0]  trial;
    logic [DEN_W+1:0]  shifted;

    // The first stage takes the input itself.
    if (i == 0) begin : g_src
      assign rem_p  = '0;
      assign quo_p  = in_num;
      assign den_p  = in_den;
      assign side_p = in_side;
      assign vld_p  = in_valid;
    end else begin : g_src
      assign rem_p  = g_step[i-1].rem_r;
      assign quo_p  = g_step[i-1].quo_r;
      assign den_p  = g_step[i-1].den_r;
      assign side_p = g_step[i-1].side_r;
      assign vld_p  = g_step[i-1].vld_r;
    end

    always_comb begin
      shifted = {rem_p, quo_p[NUM_W-1]};
      trial   = shifted - {2'b00, den_p};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_p;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[DEN_W+1]) begin
          rem_r <= trial[DEN_W:0];
          quo_r <= {quo_p[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[DEN_W:0];
          quo_r <= {quo_p[NUM_W-2:0], 1'b0};
        end
        den_r  <= den_p;
        side_r <= side_p;
      end
    end
  end

  assign out_valid = g_step[NUM_W-1].vld_r;
  assign out_quo   = g_step[NUM_W-1].quo_r;
  assign out_side  = g_step[NUM_W-1].side_r;

endmodule

// ===== src/rgb_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_hsv_converter: per-pixel RGB to HSV and HSV to RGB conversion.
// A result passes through four front stages, one divider stage per numerator bit
// (26) and two back stages. One item is taken every cycle unless the output is
// full and held. A stall freezes the whole pipeline; an empty output slot lets
// it advance.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module rgb_hsv_converter (
  input logic clk,
  input logic rst_n,
  rhc_in_if.sink    in_ch,
  rhc_out_if.source out_ch
);

  localparam int HUE_FRAC_BITS  = rhc_pkg::HUE_FRAC_BITS_DEF;
  localparam int UNIT_FRAC_BITS = rhc_pkg::UNIT_FRAC_BITS_DEF;
  localparam int SEXT   = 60 << HUE_FRAC_BITS;
  localparam int TURN   = 6 * SEXT;
  localparam int SF     = UNIT_FRAC_BITS;
  localparam int PW     = $clog2(SEXT + 1) + 1;
  // Numerator covers max(2*T*SEXT, 2*delta*S) plus rounding terms.
  localparam int NUM_W  = ((PW + 13) > (SF + 10) ? (PW + 13) : (SF + 10));
  localparam int DEN_W  = 10;
  // Hue divider side data: mode, sextant, c, brightness and the grey flag.
  localparam int HSIDE_W = 1 + 3 + 17 + 16 + 1;
  // Saturation divider side data: x, brightness result and the black flag.
  localparam int SSIDE_W = 17 + 16 + 1;
  // SEXT is 15 << (HUE_FRAC_BITS + 2); dividing by 15 is a multiplication by
  // ceil(2^28 / 15), exact for operands below 2^21.
  localparam logic [24:0] X_RECIP = 25'd17895698;
  // Dividing by 255 is a multiplication by ceil(2^32 / 255), exact for
  // operands below 2^23.
  localparam logic [24:0] B_RECIP = 25'd16843010;

  // Global advance enable: the pipeline moves unless the output is full and held.
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- Stage 1: register inputs ----------------
  logic        s1_v_r, s1_mode_r;
  logic [7:0]  s1_r_r, s1_g_r, s1_b_r;
  logic [14:0] s1_h_r;
  logic [15:0] s1_s_r, s1_bri_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode_r <= in_ch.mode;
      s1_r_r <= in_ch.red;  s1_g_r <= in_ch.green; s1_b_r <= in_ch.blue;
      s1_h_r <= in_ch.hue;  s1_s_r <= in_ch.sat;   s1_bri_r <= in_ch.bri;
    end
  end

  // ---------------- Stage 2: max/min, sextant numerator; product v*s ----------------
  logic [7:0] mx, mn, dl;
  logic [10:0] tnum;
  logic [31:0] vs;
  always_comb begin
    mx = s1_r_r; mn = s1_r_r;
    if (s1_g_r > mx) mx = s1_g_r;
    if (s1_b_r > mx) mx = s1_b_r;
    if (s1_g_r < mn) mn = s1_g_r;
    if (s1_b_r < mn) mn = s1_b_r;
    dl = mx - mn;
    if (mx == s1_r_r) begin
      tnum = (s1_g_r >= s1_b_r) ? 11'(s1_g_r - s1_b_r)
                                : 11'(6 * dl) - 11'(s1_b_r - s1_g_r);
    end else if (mx == s1_g_r) begin
      tnum = 11'(2 * dl) + 11'(s1_b_r) - 11'(s1_r_r);
    end else begin
      tnum = 11'(4 * dl) + 11'(s1_r_r) - 11'(s1_g_r);
    end
    vs = s1_bri_r * s1_s_r;
  end

  logic        s2_v_r, s2_mode_r;
  logic [7:0]  s2_mx_r, s2_dl_r;
  logic [10:0] s2_t_r;
  logic [14:0] s2_h_r;
  logic [15:0] s2_bri_r;
  logic [31:0] s2_vs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_mode_r <= s1_mode_r; s2_mx_r <= mx; s2_dl_r <= dl; s2_t_r <= tnum;
      s2_h_r <= s1_h_r; s2_bri_r <= s1_bri_r; s2_vs_r <= vs;
    end
  end

  // ---------------- Stage 3: HSV path c, sextant and t; HSV numerators ----------------
  logic [16:0] cval;
  logic [2:0]  kk;
  logic [14:0] ff, tt;
  always_comb begin
    cval = 17'((s2_vs_r + (32'd1 << (SF - 1))) >> SF);
    kk = 3'd6;
    ff = '0;
    for (int i = 5; i >= 0; i--) begin
      if (kk == 3'd6 && s2_h_r >= 15'(i * SEXT) && s2_h_r < 15'(TURN)) begin
        kk = 3'(i);
        ff = s2_h_r - 15'(i * SEXT);
      end
    end
    tt = kk[0] ? 15'(SEXT) - ff : ff;
  end

  logic        s3_v_r, s3_mode_r;
  logic [7:0]  s3_mx_r, s3_dl_r;
  logic [10:0] s3_t_r;
  logic [2:0]  s3_k_r;
  logic [14:0] s3_tt_r;
  logic [16:0] s3_c_r;
  logic [15:0] s3_bri_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_mode_r <= s2_mode_r; s3_mx_r <= s2_mx_r; s3_dl_r <= s2_dl_r;
      s3_t_r <= s2_t_r; s3_k_r <= kk; s3_tt_r <= tt; s3_c_r <= cval;
      s3_bri_r <= s2_bri_r;
    end
  end

  // ---------------- Stage 4: products c*t, T*SEXT ----------------
  logic        s4_v_r, s4_mode_r;
  logic [7:0]  s4_mx_r, s4_dl_r;
  logic [2:0]  s4_k_r;
  logic [31:0] s4_ct_r;
  logic [31:0] s4_ts_r;
  logic [16:0] s4_c_r;
  logic [15:0] s4_bri_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_mode_r <= s3_mode_r; s4_mx_r <= s3_mx_r; s4_dl_r <= s3_dl_r;
      s4_k_r <= s3_k_r; s4_c_r <= s3_c_r; s4_bri_r <= s3_bri_r;
      s4_ct_r <= 32'(s3_c_r) * 32'(s3_tt_r);
      s4_ts_r <= 32'(s3_t_r) * 32'(SEXT);
    end
  end

  // Hue and saturation go through the dividers; x and brightness have constant
  // divisors and use reciprocal multiplications, riding along as side data.
  logic [NUM_W-1:0] n_hue, n_sat;
  logic [DEN_W-1:0] d_hue, d_sat;
  logic [20:0] x_y;
  logic [45:0] x_p;
  logic [16:0] xq;
  logic [22:0] b_y;
  logic [47:0] b_p;
  logic [15:0] bq;
  always_comb begin
    n_hue = NUM_W'(2 * s4_ts_r) + NUM_W'(s4_dl_r);
    d_hue = DEN_W'(2 * s4_dl_r);
    n_sat = (NUM_W'(s4_dl_r) << (SF + 1)) + NUM_W'(s4_mx_r);
    d_sat = DEN_W'(2 * s4_mx_r);
    x_y   = 21'((s4_ct_r + 32'(SEXT / 2)) >> (HUE_FRAC_BITS + 2));
    x_p   = 46'(x_y) * 46'(X_RECIP);
    xq    = 17'(x_p >> 28);
    b_y   = (23'(s4_mx_r) << SF) + 23'd127;
    b_p   = 48'(b_y) * 48'(B_RECIP);
    bq    = 16'(b_p >> 32);
  end

  logic [NUM_W-1:0]   q_hue, q_sat;
  logic               dv0, dv1;
  logic [HSIDE_W-1:0] hside_i, hside_o;
  logic [SSIDE_W-1:0] sside_i, sside_o;
  assign hside_i = {s4_mode_r, s4_k_r, s4_c_r, s4_bri_r, (s4_dl_r == 8'd0)};
  assign sside_i = {xq, bq, (s4_mx_r == 8'd0)};

  rhc_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(HSIDE_W)) u_div_hue (
    .clk, .rst_n, .en, .in_valid(s4_v_r), .in_num(n_hue), .in_den(d_hue),
    .in_side(hside_i), .out_valid(dv0), .out_quo(q_hue), .out_side(hside_o));
  rhc_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(SSIDE_W)) u_div_sat (
    .clk, .rst_n, .en, .in_valid(s4_v_r), .in_num(n_sat), .in_den(d_sat),
    .in_side(sside_i), .out_valid(dv1), .out_quo(q_sat), .out_side(sside_o));

  // ---------------- Stage 5: assemble channels plus m ----------------
  logic        o_mode;
  logic [2:0]  o_k;
  logic [16:0] o_c, o_x;
  logic [15:0] o_bri, o_bq;
  logic        o_grey, o_black;
  assign {o_mode, o_k, o_c, o_bri, o_grey} = hside_o;
  assign {o_x, o_bq, o_black} = sside_o;

  logic signed [19:0] mm, cr, cg, cb;
  logic [NUM_W-1:0] hwrap;
  always_comb begin
    mm = 20'(o_bri) - 20'(o_c);
    cr = mm; cg = mm; cb = mm;
    case (o_k)
      3'd0: begin cr = mm + 20'(o_c); cg = mm + 20'(o_x); end
      3'd1: begin cr = mm + 20'(o_x); cg = mm + 20'(o_c); end
      3'd2: begin cg = mm + 20'(o_c); cb = mm + 20'(o_x); end
      3'd3: begin cg = mm + 20'(o_x); cb = mm + 20'(o_c); end
      3'd4: begin cr = mm + 20'(o_x); cb = mm + 20'(o_c); end
      3'd5: begin cr = mm + 20'(o_c); cb = mm + 20'(o_x); end
      default: begin cr = mm; cg = mm; cb = mm; end
    endcase
    hwrap = (q_hue >= NUM_W'(TURN)) ? q_hue - NUM_W'(TURN) : q_hue;
  end

  logic        s5_v_r, s5_mode_r;
  logic signed [19:0] s5_cr_r, s5_cg_r, s5_cb_r;
  logic [14:0] s5_h_r;
  logic [15:0] s5_s_r, s5_b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= dv0 & dv1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_mode_r <= o_mode;
      s5_cr_r <= cr; s5_cg_r <= cg; s5_cb_r <= cb;
      s5_h_r <= o_grey ? 15'd0 : 15'(hwrap);
      s5_s_r <= o_black ? 16'd0 : 16'(q_sat);
      s5_b_r <= o_bq;
    end
  end

  // ---------------- Stage 6: scale to bytes and select direction ----------------
  function automatic logic [7:0] to_byte(input logic signed [19:0] v);
    logic [29:0] p;
    logic [29:0] r;
    begin
      p = 30'(v) * 30'd255 + (30'd1 << (SF - 1));
      r = p >> SF;
      if (v <= 0) to_byte = 8'd0;
      else if (r > 30'd255) to_byte = 8'd255;
      else to_byte = r[7:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= s5_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (s5_mode_r == rhc_pkg::MODE_HSV2RGB) begin
        out_ch.red <= to_byte(s5_cr_r); out_ch.green <= to_byte(s5_cg_r);
        out_ch.blue <= to_byte(s5_cb_r);
        out_ch.hue <= '0; out_ch.sat <= '0; out_ch.bri <= '0;
      end else begin
        out_ch.red <= '0; out_ch.green <= '0; out_ch.blue <= '0;
        out_ch.hue <= s5_h_r; out_ch.sat <= s5_s_r; out_ch.bri <= s5_b_r;
      end
    end
  end

endmodule
